FILE: hdl/gtq_pkg.sv
package gtq_pkg;

   // Mode codes of the request word.
   localparam logic [1:0] MODE_ASSIGN  = 2'd0;
   localparam logic [1:0] MODE_ENQUEUE = 2'd1;
   localparam logic [1:0] MODE_DEQUEUE = 2'd2;

   // Status codes of the response word.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_ASSIGN  = 2'd0,
      OP_ENQUEUE = 2'd1,
      OP_DEQUEUE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [11:0] elem;
      logic [9:0]  grp;
   } cmd_type;

   // Front to back: head of the command queue.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } fq_type;

   // Back to front: pop and clearing pass in progress.
   typedef struct packed {
      logic pop;
      logic clearing;
   } bk_type;

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_RD1    = 9'b000000100,
      ST_RD2    = 9'b000001000,
      ST_RD3    = 9'b000010000,
      ST_LINK   = 9'b000100000,
      ST_LINK2  = 9'b001000000,
      ST_COMMIT = 9'b010000000,
      ST_FIN    = 9'b100000000
   } state_type;

endpackage

FILE: hdl/gtq_ram.sv
module gtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/gtq_front.sv
module gtq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [11:0]      req_element_id,
   input  logic [9:0]       req_group_id,
   input  gtq_pkg::bk_type  bk,
   output gtq_pkg::fq_type  fq
);
   import gtq_pkg::*;

   cmd_type    slot_ff [2];
   cmd_type    new_cmd;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   // Classify the request word into an operation.
   always_comb begin
      new_cmd.elem = req_element_id;
      new_cmd.grp  = req_group_id;
      unique case (req_mode)
         MODE_ASSIGN:  new_cmd.op = OP_ASSIGN;
         MODE_ENQUEUE: new_cmd.op = OP_ENQUEUE;
         MODE_DEQUEUE: new_cmd.op = OP_DEQUEUE;
         default:      new_cmd.op = OP_NONE;
      endcase
   end

   // Two-entry command queue; no words are taken during the clearing pass.
   assign req_stall = (cnt_ff == 2'd2) || bk.clearing;
   assign push      = req_valid && !req_stall;
   assign fq.valid  = (cnt_ff != 2'd0);
   assign fq.cmd    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ bk.pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, bk.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: hdl/gtq_back.sv
module gtq_back #(
   parameter int ELEMENT_IDS = 4096,
   parameter int NODES       = 1024,
   parameter int GROUPS      = 1024
) (
   input  logic            clock,
   input  logic            reset,
   input  gtq_pkg::fq_type fq,
   output gtq_pkg::bk_type bk,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [11:0]     rsp_out_element,
   output logic            rsp_has_element,
   output logic [1:0]      rsp_status
);
   import gtq_pkg::*;

   localparam int EW = $clog2(ELEMENT_IDS);
   localparam int NW = $clog2(NODES);
   localparam int GW = $clog2(GROUPS);
   localparam int CD = (ELEMENT_IDS > GROUPS) ? ELEMENT_IDS : GROUPS;
   localparam int CW = $clog2(CD);

   state_type      state_ff, state_in;
   cmd_type        cur_ff, cur_in;
   logic [CW-1:0]  clr_ff, clr_in;
   logic [NW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0]  rptr_ff, rptr_in, wptr_ff, wptr_in;
   logic [NW:0]    count_ff, count_in;
   logic           wrapped_ff, wrapped_in;
   logic           fvalid_ff, fvalid_in;
   logic [GW-1:0]  grp_ff, grp_in, g_ff, g_in;
   logic [NW-1:0]  nd_ff, nd_in, prev_ff, prev_in, nxt_ff, nxt_in;
   logic           join_ff, join_in;
   logic [11:0]    val_ff, val_in, res_elem_ff, res_elem_in;
   logic           res_has_ff, res_has_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [11:0]    rsp_elem_ff, rsp_elem_in;
   logic           rsp_has_ff, rsp_has_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;

   logic           goe_we;
   logic [EW-1:0]  goe_wa, goe_ra;
   logic [GW-1:0]  goe_wd, goe_rd;
   logic           grp_we;
   logic [GW-1:0]  grp_wa, grp_ra;
   logic [NW:0]    grp_wd, grp_rd;
   logic           vg_we;
   logic [NW-1:0]  vg_wa, vg_ra;
   logic [GW+11:0] vg_wd, vg_rd;
   logic           nx_we;
   logic [NW-1:0]  nx_wa, nx_ra, nx_wd, nx_rd;
   logic           fr_we;
   logic [NW-1:0]  fr_wa, fr_ra, fr_wd, fr_rd;

   logic [31:0]    elem32, gid32, clr32;
   logic [GW-1:0]  enq_grp;
   logic           elem_ok, gid_ok;
   logic [NW-1:0]  rptr_next, wptr_next;

   // Group per element id, group mark with its last node, node value and group,
   // node link, and the ring of free node indices.
   gtq_ram #(.WIDTH(GW), .DEPTH(ELEMENT_IDS)) u_goe (
      .clock(clock), .wr_en(goe_we), .wr_addr(goe_wa), .wr_data(goe_wd),
      .rd_addr(goe_ra), .rd_data(goe_rd));
   gtq_ram #(.WIDTH(NW + 1), .DEPTH(GROUPS)) u_grp (
      .clock(clock), .wr_en(grp_we), .wr_addr(grp_wa), .wr_data(grp_wd),
      .rd_addr(grp_ra), .rd_data(grp_rd));
   gtq_ram #(.WIDTH(GW + 12), .DEPTH(NODES)) u_vg (
      .clock(clock), .wr_en(vg_we), .wr_addr(vg_wa), .wr_data(vg_wd),
      .rd_addr(vg_ra), .rd_data(vg_rd));
   gtq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_nx (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr(nx_ra), .rd_data(nx_rd));
   gtq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fr (
      .clock(clock), .wr_en(fr_we), .wr_addr(fr_wa), .wr_data(fr_wd),
      .rd_addr(fr_ra), .rd_data(fr_rd));

   // Range checks and ring pointer steps.
   assign elem32    = 32'(cur_ff.elem);
   assign gid32     = 32'(cur_ff.grp);
   assign clr32     = 32'(clr_ff);
   assign elem_ok   = elem32 < ELEMENT_IDS;
   assign gid_ok    = gid32 < GROUPS;
   assign enq_grp   = elem_ok ? goe_rd : '0;
   assign rptr_next = (rptr_ff == NW'(NODES - 1)) ? '0 : rptr_ff + 1'b1;
   assign wptr_next = (wptr_ff == NW'(NODES - 1)) ? '0 : wptr_ff + 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_element = rsp_elem_ff;
   assign rsp_has_element = rsp_has_ff;
   assign rsp_status      = rsp_status_ff;

   // Sequencer: each operation walks a few read and write steps.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rptr_in       = rptr_ff;
      wptr_in       = wptr_ff;
      count_in      = count_ff;
      wrapped_in    = wrapped_ff;
      fvalid_in     = fvalid_ff;
      grp_in        = grp_ff;
      g_in          = g_ff;
      nd_in         = nd_ff;
      prev_in       = prev_ff;
      nxt_in        = nxt_ff;
      join_in       = join_ff;
      val_in        = val_ff;
      res_elem_in   = res_elem_ff;
      res_has_in    = res_has_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_elem_in   = rsp_elem_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_status_in = rsp_status_ff;
      bk.pop        = 1'b0;
      bk.clearing   = (state_ff == ST_CLEAR);

      goe_we = 1'b0;
      goe_wa = elem32[EW-1:0];
      goe_wd = '0;
      goe_ra = elem32[EW-1:0];
      grp_we = 1'b0;
      grp_wa = grp_ff;
      grp_wd = '0;
      grp_ra = (cur_ff.op == OP_ENQUEUE) ? enq_grp : vg_rd[GW-1:0];
      vg_we  = 1'b0;
      vg_wa  = nd_ff;
      vg_wd  = {cur_ff.elem, grp_ff};
      vg_ra  = head_ff;
      nx_we  = 1'b0;
      nx_wa  = nd_ff;
      nx_wd  = '0;
      nx_ra  = head_ff;
      fr_we  = 1'b0;
      fr_wa  = wptr_ff;
      fr_wd  = head_ff;
      fr_ra  = rptr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            goe_we = clr32 < ELEMENT_IDS;
            goe_wa = clr32[EW-1:0];
            grp_we = clr32 < GROUPS;
            grp_wa = clr32[GW-1:0];
            if (clr_ff == CW'(CD - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (fq.valid) begin
               bk.pop   = 1'b1;
               cur_in   = fq.cmd;
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            res_elem_in   = '0;
            res_has_in    = 1'b0;
            res_status_in = STATUS_OK;
            // A ring entry not yet written back still holds its own index.
            fvalid_in     = wrapped_ff || (rptr_ff < wptr_ff);
            unique case (cur_ff.op)
               OP_ASSIGN: begin
                  goe_we   = elem_ok;
                  goe_wd   = gid_ok ? gid32[GW-1:0] : '0;
                  state_in = ST_FIN;
               end
               OP_ENQUEUE: begin
                  if (count_ff >= (NW + 1)'(NODES)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_FIN;
                  end else begin
                     state_in = ST_RD2;
                  end
               end
               OP_DEQUEUE: begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_FIN;
                  end else begin
                     state_in = ST_RD2;
                  end
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_RD2: begin
            if (cur_ff.op == OP_ENQUEUE) begin
               grp_in  = enq_grp;
               nd_in   = fvalid_ff ? fr_rd : rptr_ff;
               rptr_in = rptr_next;
            end else begin
               val_in = vg_rd[GW+11:GW];
               g_in   = vg_rd[GW-1:0];
               nxt_in = nx_rd;
            end
            state_in = ST_RD3;
         end
         ST_RD3: begin
            if (cur_ff.op == OP_ENQUEUE) begin
               vg_we    = 1'b1;
               nx_we    = 1'b1;
               join_in  = (grp_ff != '0) && grp_rd[NW] && (count_ff != '0);
               prev_in  = grp_rd[NW-1:0];
               nx_ra    = grp_rd[NW-1:0];
               state_in = ST_LINK;
            end else begin
               // The group mark drops when its last member leaves.
               if ((g_ff != '0) && grp_rd[NW] && (grp_rd[NW-1:0] == head_ff)) begin
                  grp_we = 1'b1;
                  grp_wa = g_ff;
                  grp_wd = {1'b0, grp_rd[NW-1:0]};
               end
               if (count_ff > (NW + 1)'(1)) begin
                  head_in = nxt_ff;
               end
               count_in    = count_ff - 1'b1;
               fr_we       = 1'b1;
               wptr_in     = wptr_next;
               if (wptr_ff == NW'(NODES - 1)) begin
                  wrapped_in = 1'b1;
               end
               res_elem_in = val_ff;
               res_has_in  = 1'b1;
               state_in    = ST_FIN;
            end
         end
         ST_LINK: begin
            if (join_ff) begin
               nx_we = 1'b1;
               nx_wd = nx_rd;
               if (tail_ff == prev_ff) begin
                  tail_in = nd_ff;
               end
               state_in = ST_LINK2;
            end else begin
               if (count_ff == '0) begin
                  head_in = nd_ff;
               end else begin
                  nx_we = 1'b1;
                  nx_wa = tail_ff;
                  nx_wd = nd_ff;
               end
               tail_in  = nd_ff;
               state_in = ST_COMMIT;
            end
         end
         ST_LINK2: begin
            nx_we    = 1'b1;
            nx_wa    = prev_ff;
            nx_wd    = nd_ff;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (grp_ff != '0) begin
               grp_we = 1'b1;
               grp_wd = {1'b1, nd_ff};
            end
            count_in = count_ff + 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_elem_in   = res_elem_ff;
               rsp_has_in    = res_has_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         count_ff     <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         count_ff     <= count_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      fvalid_ff     <= fvalid_in;
      grp_ff        <= grp_in;
      g_ff          <= g_in;
      nd_ff         <= nd_in;
      prev_ff       <= prev_in;
      nxt_ff        <= nxt_in;
      join_ff       <= join_in;
      val_ff        <= val_in;
      res_elem_ff   <= res_elem_in;
      res_has_ff    <= res_has_in;
      res_status_ff <= res_status_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

FILE: hdl/grouped_team_queue_core.sv
// Steps: an assign or a rejected word passes RD1 and FIN; a dequeue RD1, RD2, RD3
// and FIN; an enqueue RD1 to RD3, LINK, LINK2 if it joins its group, COMMIT and FIN.
// The RAM reads are registered. Throughput: the back end takes one word at a time;
// a two-entry command queue keeps taking words meanwhile.
// Reset: synchronous; afterwards a clearing pass zeroes the group tables,
// and req_stall stays high until it ends.
module grouped_team_queue_core #(
   parameter int ELEMENT_IDS = 4096,
   parameter int NODES       = 1024,
   parameter int GROUPS      = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [11:0] req_element_id,
   input  logic [9:0]  req_group_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_out_element,
   output logic        rsp_has_element,
   output logic [1:0]  rsp_status
);
   import gtq_pkg::*;

   fq_type fq;
   bk_type bk;

   // Front end: takes and classifies words.
   gtq_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_element_id(req_element_id), .req_group_id(req_group_id),
      .bk(bk), .fq(fq));

   // Back end: carries out queue operations.
   gtq_back #(.ELEMENT_IDS(ELEMENT_IDS), .NODES(NODES), .GROUPS(GROUPS)) u_back (
      .clock(clock), .reset(reset), .fq(fq), .bk(bk),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_element(rsp_out_element), .rsp_has_element(rsp_has_element),
      .rsp_status(rsp_status));

endmodule

FILE: hdl/gtq_check.sv
module gtq_check (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_out_element,
   input logic        rsp_has_element,
   input logic [1:0]  rsp_status
);
   import gtq_pkg::*;

   // The clearing pass blocks input right after reset.
   assert property (@(posedge clock) reset |=> req_stall && !rsp_valid)
      else $error("input open or response shown right after reset");

   // A dequeued element always comes with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_element |-> rsp_status == STATUS_OK)
      else $error("element returned with error status");

   // Without an element the element field is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_element |-> rsp_out_element == 12'd0)
      else $error("element field set without element");

   // Only defined status codes appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_EMPTY)
         || (rsp_status == STATUS_FULL))
      else $error("undefined status code");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_element)
         && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind grouped_team_queue_core gtq_check u_check (.*);
